>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define LBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define LBD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> hw/rtl/lbd_pkg.sv
// ----------------------------------------------------------------------------
// LZSS bitstream decoder package
// Shared types, register indexes and constants of the decoder.
// ----------------------------------------------------------------------------
package lbd_pkg;

  localparam int FLAG_SIZE = 1;
  localparam int BYTE_SIZE = 8;
  localparam int MIN_REPETITION = 2;
  localparam int OFFSET_BITS_MIN = 8;
  localparam int OFFSET_BITS_MAX = 12;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] REG_LENGTH_BITS = 2'd1;
  localparam logic [1:0] REG_TOTAL_LENGTH = 2'd2;

  localparam logic [3:0] OFFSET_BITS_RESET = 4'd12;
  localparam logic [2:0] LENGTH_BITS_RESET = 3'd4;
  localparam logic [23:0] TOTAL_LENGTH_RESET = 24'd1;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_LITERAL,
    PH_OFFSET,
    PH_LENGTH
  } phase_t;

  typedef enum logic [1:0] {
    CMD_LITERAL,
    CMD_COPY,
    CMD_FAULT
  } cmd_kind_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_EMIT
  } bstate_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [11:0] data;
    logic [4:0]  len;
    logic        last;
  } cmd_t;

  function automatic logic [11:0] low_mask(input logic [3:0] w);
    logic [12:0] t;
    t = (13'd1 << w) - 13'd1;
    return t[11:0];
  endfunction

endpackage

>>> hw/rtl/lbd_queue.sv
// ----------------------------------------------------------------------------
// LZSS decoder command queue
// Short FIFO of decoded tokens between the parser and the copy engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          flush,
  input  logic          push,
  input  lbd_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output lbd_pkg::cmd_t head
);

  localparam int PW = $clog2(lbd_pkg::QUEUE_DEPTH);

  lbd_pkg::cmd_t entries [lbd_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full  = (count == (PW+1)'(lbd_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_cmd;
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  `LBD_NEVER(a_no_push_full, push && full && !pop, "push into a full queue")
  `LBD_NEVER(a_no_pop_empty, pop && empty, "pop from an empty queue")
  `LBD_ASSERT(a_count_range, count <= (PW+1)'(lbd_pkg::QUEUE_DEPTH), "queue count overflow")

endmodule

>>> hw/rtl/lbd_front.sv
// ----------------------------------------------------------------------------
// LZSS decoder token parser
// Parses stream words, a token field per cycle unless stalled; checks bounds.
// ----------------------------------------------------------------------------
module lbd_front #(
  parameter int WINDOW_BYTES = 4096,
  parameter int MAX_LENGTH_FIELD_BITS = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          restart,
  input  logic [23:0]   restart_total,
  input  logic [3:0]    offset_bits,
  input  logic [2:0]    length_bits,
  input  logic          word_valid,
  output logic          word_ready_out,
  input  logic [31:0]   word_in,
  output logic          push,
  output lbd_pkg::cmd_t push_cmd,
  input  logic          q_full
);

  localparam int BW = $clog2(WINDOW_BYTES) + 1;

  logic [31:0]     word;
  logic            word_ready;
  logic [31:0]     bit_store;
  logic [5:0]      bits_held;
  logic [23:0]     bytes_left;
  logic [BW-1:0]   bytes_written;
  lbd_pkg::phase_t phase;
  logic [11:0]     held_offset;
  logic            halted;

  logic            word_ready_next;
  logic [31:0]     bit_store_next;
  logic [5:0]      bits_held_next;
  logic [23:0]     bytes_left_next;
  logic [BW-1:0]   bytes_written_next;
  lbd_pkg::phase_t phase_next;
  logic [11:0]     held_offset_next;
  logic            halted_next;

  logic [3:0]  wo;
  logic [3:0]  wl;
  logic [3:0]  n;
  logic [3:0]  need;
  logic        have_store;
  logic        step;
  logic [11:0] val;
  logic [4:0]  len;
  logic [12:0] back_dist;
  logic [BW:0] bw_sum;
  logic        accept;

  assign word_ready_out = !word_ready;
  assign accept = word_valid && !word_ready;

  always_comb begin
    if (offset_bits < 4'(lbd_pkg::OFFSET_BITS_MIN)) begin
      wo = 4'(lbd_pkg::OFFSET_BITS_MIN);
    end else if (offset_bits > 4'(lbd_pkg::OFFSET_BITS_MAX)) begin
      wo = 4'(lbd_pkg::OFFSET_BITS_MAX);
    end else begin
      wo = offset_bits;
    end
    if (length_bits == 3'd0) begin
      wl = 4'd1;
    end else if ({1'b0, length_bits} > 4'(MAX_LENGTH_FIELD_BITS)) begin
      wl = 4'(MAX_LENGTH_FIELD_BITS);
    end else begin
      wl = {1'b0, length_bits};
    end
  end

  always_comb begin
    case (phase)
      lbd_pkg::PH_FLAG:    n = 4'(lbd_pkg::FLAG_SIZE);
      lbd_pkg::PH_LITERAL: n = 4'(lbd_pkg::BYTE_SIZE);
      lbd_pkg::PH_OFFSET:  n = wo;
      default:             n = wl;
    endcase
  end

  assign have_store = (bits_held >= {2'b00, n});
  assign need = n - bits_held[3:0];
  assign step = !halted && (have_store || word_ready) && !q_full;

  always_comb begin
    word_ready_next    = word_ready;
    bit_store_next     = bit_store;
    bits_held_next     = bits_held;
    bytes_left_next    = bytes_left;
    bytes_written_next = bytes_written;
    phase_next         = phase;
    held_offset_next   = held_offset;
    halted_next        = halted;
    push               = 1'b0;
    push_cmd           = '{kind: lbd_pkg::CMD_FAULT, data: '0, len: '0, last: 1'b0};
    val                = '0;
    len                = '0;
    back_dist          = '0;
    bw_sum             = '0;
    if (step) begin
      if (have_store) begin
        val            = bit_store[11:0] & lbd_pkg::low_mask(n);
        bit_store_next = bit_store >> n;
        bits_held_next = bits_held - {2'b00, n};
      end else begin
        val = ((bit_store[11:0] << need) | (word[11:0] & lbd_pkg::low_mask(need)))
              & lbd_pkg::low_mask(n);
        bit_store_next  = word >> need;
        bits_held_next  = 6'd32 - {2'b00, need};
        word_ready_next = 1'b0;
      end
      case (phase)
        lbd_pkg::PH_FLAG: begin
          phase_next = val[0] ? lbd_pkg::PH_LITERAL : lbd_pkg::PH_OFFSET;
        end
        lbd_pkg::PH_LITERAL: begin
          phase_next = lbd_pkg::PH_FLAG;
          push = 1'b1;
          if (bytes_left == '0) begin
            halted_next = 1'b1;
          end else begin
            push_cmd = '{kind: lbd_pkg::CMD_LITERAL, data: {4'd0, val[7:0]}, len: 5'd1,
                         last: (bytes_left == 24'd1)};
            bytes_left_next = bytes_left - 24'd1;
            bw_sum = {1'b0, bytes_written} + (BW+1)'(1);
            bytes_written_next = (bw_sum > (BW+1)'(WINDOW_BYTES)) ?
                                 BW'(WINDOW_BYTES) : bw_sum[BW-1:0];
            halted_next = (bytes_left == 24'd1);
          end
        end
        lbd_pkg::PH_OFFSET: begin
          held_offset_next = val;
          phase_next = lbd_pkg::PH_LENGTH;
        end
        default: begin
          phase_next = lbd_pkg::PH_FLAG;
          push = 1'b1;
          len  = {1'b0, val[3:0]} + 5'(lbd_pkg::MIN_REPETITION);
          back_dist = {1'b0, held_offset} + 13'd1;
          if ({19'd0, len} > bytes_left || {1'b0, back_dist} > 14'(bytes_written))
          begin
            halted_next = 1'b1;
          end else begin
            push_cmd = '{kind: lbd_pkg::CMD_COPY, data: held_offset, len: len,
                         last: ({19'd0, len} == bytes_left)};
            bytes_left_next = bytes_left - {19'd0, len};
            bw_sum = {1'b0, bytes_written} + (BW+1)'(len);
            bytes_written_next = (bw_sum > (BW+1)'(WINDOW_BYTES)) ?
                                 BW'(WINDOW_BYTES) : bw_sum[BW-1:0];
            halted_next = ({19'd0, len} == bytes_left);
          end
        end
      endcase
      if (halted_next) begin
        word_ready_next = 1'b0;
      end
    end
    if (accept) begin
      word_ready_next = !halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word <= word_in;
    end
    if (rst || restart) begin
      word_ready    <= 1'b0;
      bit_store     <= '0;
      bits_held     <= '0;
      bytes_left    <= rst ? lbd_pkg::TOTAL_LENGTH_RESET : restart_total;
      bytes_written <= '0;
      phase         <= lbd_pkg::PH_FLAG;
      held_offset   <= '0;
      halted        <= 1'b0;
    end else begin
      word_ready    <= word_ready_next;
      bit_store     <= bit_store_next;
      bits_held     <= bits_held_next;
      bytes_left    <= bytes_left_next;
      bytes_written <= bytes_written_next;
      phase         <= phase_next;
      held_offset   <= held_offset_next;
      halted        <= halted_next;
    end
  end

endmodule

>>> hw/rtl/lbd_back.sv
// ----------------------------------------------------------------------------
// LZSS decoder copy engine
// Executes literal, copy and fault commands against the history window.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbd_back #(
  parameter int WINDOW_BYTES = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          restart,
  input  logic          q_empty,
  input  lbd_pkg::cmd_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_last,
  output logic          out_fault
);

  localparam int AW = $clog2(WINDOW_BYTES);

  logic [7:0] mem [WINDOW_BYTES];
  logic [7:0] rdata;

  lbd_pkg::bstate_t state;
  lbd_pkg::bstate_t state_next;
  logic [AW-1:0] wp;
  logic [AW-1:0] wp_next;
  logic [12:0]   back_dist;
  logic [12:0]   back_dist_next;
  logic [4:0]    remaining;
  logic [4:0]    remaining_next;
  logic          cp_last;
  logic          cp_last_next;

  logic          load;
  logic [7:0]    load_byte;
  logic          load_last;
  logic          load_fault;
  logic          we;
  logic [7:0]    wdata;
  logic          out_free;
  logic [AW-1:0] rd_addr;

  assign out_free = !out_valid || out_ready;
  assign rd_addr  = wp - back_dist[AW-1:0];

  always_comb begin
    state_next     = state;
    wp_next        = wp;
    back_dist_next = back_dist;
    remaining_next = remaining;
    cp_last_next   = cp_last;
    pop            = 1'b0;
    load           = 1'b0;
    load_byte      = '0;
    load_last      = 1'b0;
    load_fault     = 1'b0;
    we             = 1'b0;
    wdata          = '0;
    case (state)
      lbd_pkg::B_IDLE: begin
        if (!q_empty && out_free) begin
          pop = 1'b1;
          case (head.kind)
            lbd_pkg::CMD_LITERAL: begin
              we        = 1'b1;
              wdata     = head.data[7:0];
              wp_next   = wp + AW'(1);
              load      = 1'b1;
              load_byte = head.data[7:0];
              load_last = head.last;
            end
            lbd_pkg::CMD_COPY: begin
              back_dist_next = {1'b0, head.data} + 13'd1;
              remaining_next = head.len;
              cp_last_next   = head.last;
              state_next     = lbd_pkg::B_READ;
            end
            default: begin
              load       = 1'b1;
              load_fault = 1'b1;
            end
          endcase
        end
      end
      lbd_pkg::B_READ: begin
        state_next = lbd_pkg::B_EMIT;
      end
      lbd_pkg::B_EMIT: begin
        if (out_free) begin
          we             = 1'b1;
          wdata          = rdata;
          wp_next        = wp + AW'(1);
          load           = 1'b1;
          load_byte      = rdata;
          load_last      = cp_last && (remaining == 5'd1);
          remaining_next = remaining - 5'd1;
          state_next     = (remaining == 5'd1) ? lbd_pkg::B_IDLE : lbd_pkg::B_READ;
        end
      end
      default: begin
        state_next = lbd_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wp] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state     <= lbd_pkg::B_IDLE;
      wp        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      wp    <= wp_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    back_dist <= back_dist_next;
    remaining <= remaining_next;
    cp_last   <= cp_last_next;
    if (load) begin
      out_byte  <= load_byte;
      out_last  <= load_last;
      out_fault <= load_fault;
    end
  end

  `LBD_NEVER(a_emit_has_bytes, state == lbd_pkg::B_EMIT && remaining == '0,
             "copy engine emitting with nothing left")
  `LBD_NEVER(a_no_load_stalled, load && out_valid && !out_ready,
             "result overwritten while waiting")

endmodule

>>> hw/rtl/lzss_bitstream_decoder_core.sv
// ----------------------------------------------------------------------------
// LZSS bitstream decoder core
// Expands 32-bit LZSS stream words into bytes through a history window.
// ----------------------------------------------------------------------------
// The parser consumes one token field per cycle unless the queue is full, and
// takes a new word once the held bits run short; every token spends at least
// nine bits on two or three fields, so a word carries about ten fields at
// most. The copy engine puts a literal in the output register and sends each
// copied byte through READ and EMIT, since every byte goes through a
// registered read of the history memory before it is written back; overlapping
// copies therefore work at any distance. One word can expand to dozens of
// bytes, so the copy engine sets the pace. A four-entry command queue lets
// both sides stall on their own. Any register write restarts decoding.
// m_tlast marks the last byte of the output, and m_tuser marks a fault word,
// after which all input is dropped until the next register write or reset.
module lzss_bitstream_decoder_core #(
  parameter int WINDOW_BYTES = 4096,
  parameter int MAX_LENGTH_FIELD_BITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // stream_word[31:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte[7:0]
  output logic        m_tlast,
  output logic        m_tuser    // fault
);

  logic [3:0]    offset_bits;
  logic [2:0]    length_bits;
  logic [23:0]   total_length;
  logic          restart;
  logic [23:0]   restart_total;
  logic          push;
  lbd_pkg::cmd_t push_cmd;
  logic          q_full;
  logic          q_empty;
  logic          pop;
  lbd_pkg::cmd_t head;

  assign restart = cfg_we && (cfg_index == lbd_pkg::REG_OFFSET_BITS ||
                              cfg_index == lbd_pkg::REG_LENGTH_BITS ||
                              cfg_index == lbd_pkg::REG_TOTAL_LENGTH);
  assign restart_total = (cfg_index == lbd_pkg::REG_TOTAL_LENGTH) ? cfg_data : total_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits  <= lbd_pkg::OFFSET_BITS_RESET;
      length_bits  <= lbd_pkg::LENGTH_BITS_RESET;
      total_length <= lbd_pkg::TOTAL_LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lbd_pkg::REG_OFFSET_BITS:  offset_bits  <= cfg_data[3:0];
        lbd_pkg::REG_LENGTH_BITS:  length_bits  <= cfg_data[2:0];
        lbd_pkg::REG_TOTAL_LENGTH: total_length <= cfg_data;
        default: ;
      endcase
    end
  end

  lbd_front #(
    .WINDOW_BYTES(WINDOW_BYTES),
    .MAX_LENGTH_FIELD_BITS(MAX_LENGTH_FIELD_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .restart(restart),
    .restart_total(restart_total),
    .offset_bits(offset_bits),
    .length_bits(length_bits),
    .word_valid(s_tvalid),
    .word_ready_out(s_tready),
    .word_in(s_tdata),
    .push(push),
    .push_cmd(push_cmd),
    .q_full(q_full)
  );

  lbd_queue u_queue (
    .clk(clk),
    .rst(rst),
    .flush(restart),
    .push(push),
    .push_cmd(push_cmd),
    .full(q_full),
    .pop(pop),
    .empty(q_empty),
    .head(head)
  );

  lbd_back #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .restart(restart),
    .q_empty(q_empty),
    .head(head),
    .pop(pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_byte(m_tdata),
    .out_last(m_tlast),
    .out_fault(m_tuser)
  );

endmodule
